// File: design/pixel_quantize_bit_packer_defines.svh
// assertion macros for the pixel quantize bit packer checker
`ifndef PIXEL_QUANTIZE_BIT_PACKER_DEFINES_SVH
`define PIXEL_QUANTIZE_BIT_PACKER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define PQBP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pqbp assertion failed");

// antecedent implies consequent in the next cycle
`define PQBP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pqbp assertion failed");

// check that also covers the cycles in reset
`define PQBP_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("pqbp assertion failed");

`endif

// File: design/pqbp_pkg.sv
// shared types and constants of the pixel quantize bit packer
package pqbp_pkg;

    localparam logic [7:0] MAX_GRAY_RST = 8'd255;
    localparam logic       REG_MAX_GRAY = 1'b0;

    localparam int OFIFO_DEPTH = 8;
    localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);

    typedef struct packed {
        logic [7:0] max_gray;
        logic [3:0] width;
    } t_cfg;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       final_byte;
    } t_beat;

    typedef struct packed {
        logic [1:0] num;
        t_beat      beat0;
        t_beat      beat1;
    } t_push;

endpackage

// File: design/pqbp_if.sv
// stream interfaces for pixel input and packed byte output
interface pqbp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_value;
    logic       last_pixel;

    modport source (output valid, output pixel_value, output last_pixel, input ready);
    modport sink   (input valid, input pixel_value, input last_pixel, output ready);
endinterface

interface pqbp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] packed_byte;
    logic       final_byte;

    modport source (output valid, output packed_byte, output final_byte, input ready);
    modport sink   (input valid, input packed_byte, input final_byte, output ready);
endinterface

// File: design/pixel_quantize_bit_packer.sv
// top level of the pixel quantize bit packer
//
// takes one 8-bit pixel per beat, scales it to pixel * max_gray / 255 and
// packs the result msb-first into bytes, using a field as wide as the bit
// length of max_gray (0 to 8 bits). a pixel marked last flushes any partly
// filled byte with zero padding and the last byte of the image carries
// final_byte. the block takes a new pixel every cycle while input ready
// is high; a pixel is held in the input register, where the 8x8 multiply,
// the divide by 255 and the shift-or packing run, and its bytes are
// written into an 8-entry output queue. the output side moves one byte per
// cycle while the receiver is ready, so sustained input rate is one pixel
// per cycle as long as pixels average at most one byte each (max_gray up
// to 255); input ready drops while the queue could not absorb two more
// beats for the held pixel and the new one. max_gray is written over apb
// at byte address 0; the user must write it only while the block is idle,
// which the block does not enforce. no clearing pass follows reset.
module pixel_quantize_bit_packer
    import pqbp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    pqbp_in_if.sink     i_pix,
    pqbp_out_if.source  o_byte
);

    t_cfg              cfg;
    t_push             push;
    t_beat             beat;
    logic [OFIFO_AW:0] level;

    // register file: max_gray and its bit length
    pqbp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // input register, quantizer and packing state
    pqbp_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_pix.valid),
        .i_pixel (i_pix.pixel_value),
        .i_last  (i_pix.last_pixel),
        .i_level (level),
        .o_ready (i_pix.ready),
        .o_push  (push)
    );

    // output queue, up to two beats in and one out per cycle
    pqbp_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ready (o_byte.ready),
        .o_valid (o_byte.valid),
        .o_beat  (beat),
        .o_level (level)
    );

    assign o_byte.packed_byte = beat.packed_byte;
    assign o_byte.final_byte  = beat.final_byte;

endmodule

// File: design/pqbp_cfg.sv
// apb register file holding max_gray and the derived field width
module pqbp_cfg
    import pqbp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic [7:0] r_max_gray;
    logic [7:0] n_max_gray;
    logic       wr_en;

    // bit length of the gray level, 0 to 8
    function automatic logic [3:0] bit_len(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int k = 0; k < 8; k++) begin
            if (v[k]) begin
                n = 4'(k + 1);
            end
        end
        return n;
    endfunction

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_MAX_GRAY);

    always_comb begin
        n_max_gray = r_max_gray;
        if (wr_en) begin
            n_max_gray = pwdata[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_gray <= MAX_GRAY_RST;
        end else begin
            r_max_gray <= n_max_gray;
        end
    end

    assign prdata = (paddr[2] == REG_MAX_GRAY) ? {24'd0, r_max_gray} : 32'd0;

    assign o_cfg.max_gray = r_max_gray;
    assign o_cfg.width    = bit_len(r_max_gray);

endmodule

// File: design/pqbp_pack.sv
// input register, quantizer and msb-first packing state
module pqbp_pack
    import pqbp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_valid,
    input  logic [7:0]        i_pixel,
    input  logic              i_last,
    input  logic [OFIFO_AW:0] i_level,
    output logic              o_ready,
    output t_push             o_push
);

    localparam int LW = OFIFO_AW + 2;

    logic       r_valid;
    logic [7:0] r_pixel;
    logic       r_last;
    logic [7:0] r_part;
    logic [2:0] r_used;

    logic       n_valid;
    logic [7:0] n_part;
    logic [2:0] n_used;

    logic [15:0] prod;
    logic [15:0] qsum;
    logic [7:0]  q;
    logic [3:0]  total;
    logic [4:0]  shamt;
    logic [15:0] qsh;
    logic [15:0] window;
    logic        full;
    logic [7:0]  part_keep;
    logic        flush;
    logic [LW-1:0] need;

    // room for the held item and the new one, two beats each at most
    assign need    = LW'(i_level) + (r_valid ? LW'(2) : LW'(0)) + LW'(2);
    assign o_ready = (need <= LW'(OFIFO_DEPTH));
    assign n_valid = i_valid && o_ready;

    // q = pixel * max_gray / 255, exact for 16-bit products
    assign prod  = 16'(r_pixel) * 16'(i_cfg.max_gray);
    assign qsum  = prod + 16'd1 + {8'd0, prod[15:8]};
    assign q     = qsum[15:8];

    assign total  = {1'b0, r_used} + i_cfg.width;
    assign shamt  = 5'd16 - {1'b0, total};
    assign qsh    = {8'd0, q} << shamt;
    assign window = {r_part, 8'd0} | qsh;
    assign full   = total[3];

    assign part_keep = full ? window[7:0] : window[15:8];
    assign flush     = r_last && (total[2:0] != 3'd0);

    always_comb begin
        o_push.num   = 2'd0;
        o_push.beat0 = '{packed_byte: window[15:8], final_byte: 1'b0};
        o_push.beat1 = '{packed_byte: part_keep, final_byte: 1'b1};
        if (r_valid) begin
            if (full && flush) begin
                o_push.num = 2'd2;
            end else if (full) begin
                o_push.num              = 2'd1;
                o_push.beat0.final_byte = r_last;
            end else if (flush) begin
                o_push.num   = 2'd1;
                o_push.beat0 = '{packed_byte: part_keep, final_byte: 1'b1};
            end
        end
    end

    always_comb begin
        n_part = r_part;
        n_used = r_used;
        if (r_valid) begin
            if (r_last) begin
                n_part = 8'd0;
                n_used = 3'd0;
            end else begin
                n_part = part_keep;
                n_used = total[2:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_part  <= 8'd0;
            r_used  <= 3'd0;
        end else begin
            r_valid <= n_valid;
            r_part  <= n_part;
            r_used  <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_valid) begin
            r_pixel <= i_pixel;
            r_last  <= i_last;
        end
    end

endmodule

// File: design/pqbp_ofifo.sv
// output queue taking up to two beats per cycle, one out per cycle
module pqbp_ofifo
    import pqbp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_push             i_push,
    input  logic              i_ready,
    output logic              o_valid,
    output t_beat             o_beat,
    output logic [OFIFO_AW:0] o_level
);

    t_beat               r_mem [OFIFO_DEPTH];
    logic [OFIFO_AW-1:0] r_wr;
    logic [OFIFO_AW-1:0] r_rd;
    logic [OFIFO_AW:0]   r_level;

    logic [OFIFO_AW-1:0] n_wr;
    logic [OFIFO_AW-1:0] n_rd;
    logic [OFIFO_AW:0]   n_level;
    logic [OFIFO_AW-1:0] wr_next;
    logic                pop;

    assign o_valid = (r_level != '0);
    assign o_beat  = r_mem[r_rd];
    assign o_level = r_level;
    assign pop     = o_valid && i_ready;
    assign wr_next = r_wr + OFIFO_AW'(1);

    always_comb begin
        n_wr    = r_wr + OFIFO_AW'(i_push.num);
        n_rd    = pop ? r_rd + OFIFO_AW'(1) : r_rd;
        n_level = r_level + (OFIFO_AW + 1)'(i_push.num) - (OFIFO_AW + 1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr] <= i_push.beat0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr_next] <= i_push.beat1;
        end
    end

endmodule

// File: design/pqbp_checker.sv
// port-level checks of the pixel quantize bit packer and their bind
`include "pixel_quantize_bit_packer_defines.svh"

module pqbp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_psel,
    input logic        i_penable,
    input logic        i_pwrite,
    input logic [2:0]  i_paddr,
    input logic [31:0] i_pwdata,
    input logic [31:0] i_prdata,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  i_out_byte,
    input logic        i_out_final
);

    // a stalled output beat holds
    `PQBP_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_byte) && $stable(i_out_final))

    // nothing is queued right after reset
    `PQBP_ASSERT_RST(a_rst_empty, !i_rst_n, !i_out_valid)

    // max_gray reads back what was just written
    `PQBP_ASSERT_IMPL(a_cfg_readback, i_psel && i_penable && i_pwrite && !i_paddr[2] ##1 i_psel && !i_pwrite && !i_paddr[2], i_prdata[7:0] == $past(i_pwdata[7:0]))

endmodule

bind pixel_quantize_bit_packer pqbp_checker u_pqbp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_psel      (psel),
    .i_penable   (penable),
    .i_pwrite    (pwrite),
    .i_paddr     (paddr),
    .i_pwdata    (pwdata),
    .i_prdata    (prdata),
    .i_out_valid (o_byte.valid),
    .i_out_ready (o_byte.ready),
    .i_out_byte  (o_byte.packed_byte),
    .i_out_final (o_byte.final_byte)
);
